FILE: sv/etpi_pkg.sv
// Shared types and codes for the expert token permutation index block.
package etpi_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_FETCH = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic REG_EXPERT_TOTAL = 1'b0;

    // Width of a routing row, and so the most experts any map can use.
    localparam int EXPERT_SLOTS = 16;

    // Request word.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] expert_mask;
        logic        final_row;
        logic [3:0]  query_expert;
    } etpi_req_t;

    // Response word.
    typedef struct packed {
        logic        entry_valid;
        logic [7:0]  token_index;
        logic [3:0]  expert_index;
        logic [11:0] flat_index;
        logic [8:0]  expert_count;
        logic        last_entry;
        logic        overflow_flag;
    } etpi_rsp_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_SEL,
        ST_SCAN_CHK,
        ST_EMIT
    } etpi_state_t;

endpackage

FILE: sv/expert_token_permutation_index_core.sv
// Top level of the expert token permutation index block: row store, counts and dispatch scan.
//
//  Channel   Direction  Handshake               Payload
//  req       in         req_valid / req_ready   etpi_req_t word
//  rsp       out        rsp_valid / rsp_ready   etpi_rsp_t word
//  cfg       in         APB (psel, penable)     expert_total at byte address 0
//
// Load and unused codes finish in the accept cycle; a query, or a fetch before the final row,
// goes on to the emit state. A fetch after the final row steps over used-up experts one per
// cycle, issues the first row read, checks one row per cycle up to the next routed token, then
// emits. Reset clears counts, cursor and flags, not the row store. req_ready stays low until
// the word enters the output register, which waits only while the previous word is still held
// there for rsp_ready.
module expert_token_permutation_index_core
    import etpi_pkg::*;
    #(
        parameter int MAX_TOKENS  = 256,
        parameter int MAX_EXPERTS = 16
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        req_valid,
        output logic        req_ready,
        input  etpi_req_t   req,
        output logic        rsp_valid,
        input  logic        rsp_ready,
        output etpi_rsp_t   rsp,
        input  logic        psel,
        input  logic        penable,
        input  logic        pwrite,
        input  logic [2:0]  paddr,
        input  logic [31:0] pwdata,
        output logic [31:0] prdata,
        output logic        pready
    );

    localparam int ADDR_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
    localparam int NE_CAP = (MAX_EXPERTS < EXPERT_SLOTS) ? MAX_EXPERTS : EXPERT_SLOTS;
    localparam logic [4:0]       NE_CAP_V   = 5'(NE_CAP);
    localparam logic [CNT_W-1:0] TOKENS_MAX = CNT_W'(MAX_TOKENS);

    // Registers.
    etpi_state_t      state_reg, state_next;
    logic [4:0]       expert_total_reg, expert_total_next;
    logic [CNT_W-1:0] rows_loaded_reg, rows_loaded_next;
    logic [CNT_W-1:0] counts_reg [EXPERT_SLOTS];
    logic [CNT_W-1:0] counts_next [EXPERT_SLOTS];
    logic [4:0]       cur_expert_reg, cur_expert_next;
    logic [CNT_W-1:0] cur_token_reg, cur_token_next;
    logic [CNT_W-1:0] hits_reg, hits_next;
    logic             map_complete_reg, map_complete_next;
    logic             dropped_reg, dropped_next;
    etpi_rsp_t        pend_reg, pend_next;
    logic             rsp_valid_reg, rsp_valid_next;
    etpi_rsp_t        rsp_reg, rsp_next;

    // Row store ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    // Working signals.
    logic [4:0]       ne;
    logic [4:0]       et_min1;
    logic [15:0]      use_mask;
    logic [15:0]      row_mask;
    logic [3:0]       cur_e4;
    logic [CNT_W-1:0] cur_count;
    logic [CNT_W-1:0] hits_inc;
    logic [CNT_W:0]   token_inc;
    logic [CNT_W-1:0] rows_base;
    logic             later_any;
    logic             row_hit;
    logic [CNT_W+4:0] flat_prod;
    logic             cfg_write;

    etpi_ram
        #(
            .WIDTH(16),
            .DEPTH(MAX_TOKENS)
        )
        u_route_store
        (
            .clk  (clk),
            .we   (ram_we),
            .waddr(ram_waddr),
            .wdata(ram_wdata),
            .re   (ram_re),
            .raddr(ram_raddr),
            .rdata(ram_rdata)
        );

    // Low bits of a count or token, zero extended where the count is narrower.
    function automatic logic [8:0] low9(input logic [CNT_W-1:0] v);
        logic [CNT_W+8:0] w;
        w = {9'b0, v};
        return w[8:0];
    endfunction

    function automatic logic [7:0] low8(input logic [CNT_W-1:0] v);
        logic [CNT_W+7:0] w;
        w = {8'b0, v};
        return w[7:0];
    endfunction

    function automatic logic [11:0] low12(input logic [CNT_W+4:0] v);
        logic [CNT_W+16:0] w;
        w = {12'b0, v};
        return w[11:0];
    endfunction

    // Experts in use: zero acts as one, and the count is capped by MAX_EXPERTS and the row width.
    always_comb
    begin
        et_min1 = (expert_total_reg == 5'd0) ? 5'd1 : expert_total_reg;
        ne      = (et_min1 > NE_CAP_V) ? NE_CAP_V : et_min1;
        for (int i = 0; i < EXPERT_SLOTS; i++)
        begin
            use_mask[i] = (5'(i) < ne);
        end
    end

    // Configuration port: single register, always ready.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_EXPERT_TOTAL) ? {27'b0, expert_total_reg} : 32'b0;

    always_comb
    begin
        expert_total_next = expert_total_reg;
        if (cfg_write && (paddr[2] == REG_EXPERT_TOTAL))
        begin
            expert_total_next = pwdata[4:0];
        end
    end

    // Scan helpers for the expert under the cursor.
    always_comb
    begin
        cur_e4    = cur_expert_reg[3:0];
        cur_count = counts_reg[cur_e4];
        hits_inc  = hits_reg + CNT_W'(1);
        token_inc = {1'b0, cur_token_reg} + (CNT_W + 1)'(1);
        row_hit   = ram_rdata[cur_e4];
        flat_prod = cur_token_reg * ne;
        later_any = 1'b0;
        for (int j = 0; j < EXPERT_SLOTS; j++)
        begin
            if ((5'(j) > cur_expert_reg) && (5'(j) < ne) && (counts_reg[j] != '0))
            begin
                later_any = 1'b1;
            end
        end
    end

    // Sequencer: next state, state updates and row store control.
    always_comb
    begin
        state_next        = state_reg;
        rows_loaded_next  = rows_loaded_reg;
        counts_next       = counts_reg;
        cur_expert_next   = cur_expert_reg;
        cur_token_next    = cur_token_reg;
        hits_next         = hits_reg;
        map_complete_next = map_complete_reg;
        dropped_next      = dropped_reg;
        pend_next         = pend_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        rsp_next          = rsp_reg;
        ram_we            = 1'b0;
        ram_waddr         = rows_loaded_reg[ADDR_W-1:0];
        row_mask          = req.expert_mask & use_mask;
        ram_wdata         = row_mask;
        ram_re            = 1'b0;
        ram_raddr         = cur_token_reg[ADDR_W-1:0];
        rows_base         = map_complete_reg ? '0 : rows_loaded_reg;
        req_ready         = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    pend_next               = '0;
                    pend_next.overflow_flag = dropped_reg;
                    case (req.req_type)
                        REQ_LOAD:
                        begin
                            // A load after the final row opens a new map.
                            if (map_complete_reg)
                            begin
                                for (int i = 0; i < EXPERT_SLOTS; i++)
                                begin
                                    counts_next[i] = '0;
                                end
                                cur_expert_next   = '0;
                                cur_token_next    = '0;
                                hits_next         = '0;
                                map_complete_next = 1'b0;
                                dropped_next      = 1'b0;
                                rows_loaded_next  = '0;
                            end
                            ram_waddr = rows_base[ADDR_W-1:0];
                            if (rows_base < TOKENS_MAX)
                            begin
                                ram_we           = 1'b1;
                                rows_loaded_next = rows_base + CNT_W'(1);
                                for (int i = 0; i < EXPERT_SLOTS; i++)
                                begin
                                    if (row_mask[i])
                                    begin
                                        counts_next[i] = counts_next[i] + CNT_W'(1);
                                    end
                                end
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                            if (req.final_row)
                            begin
                                map_complete_next = 1'b1;
                            end
                        end
                        REQ_FETCH:
                        begin
                            state_next = map_complete_reg ? ST_SCAN_SEL : ST_EMIT;
                        end
                        REQ_QUERY:
                        begin
                            pend_next.expert_index = req.query_expert;
                            if ({1'b0, req.query_expert} < ne)
                            begin
                                pend_next.expert_count = low9(counts_reg[req.query_expert]);
                            end
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN_SEL:
            begin
                // Step over experts whose routed tokens have all been handed out.
                if (cur_expert_reg >= ne)
                begin
                    state_next = ST_EMIT;
                end
                else if (hits_reg == cur_count)
                begin
                    cur_expert_next = cur_expert_reg + 5'd1;
                    cur_token_next  = '0;
                    hits_next       = '0;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                if (row_hit)
                begin
                    pend_next.entry_valid  = 1'b1;
                    pend_next.token_index  = low8(cur_token_reg);
                    pend_next.expert_index = cur_e4;
                    pend_next.flat_index   = low12(flat_prod) + {8'b0, cur_e4};
                    pend_next.expert_count = low9(cur_count);
                    pend_next.last_entry   = !((hits_inc != cur_count) || later_any);
                    if (token_inc < {1'b0, rows_loaded_reg})
                    begin
                        cur_token_next = token_inc[CNT_W-1:0];
                        hits_next      = hits_inc;
                    end
                    else
                    begin
                        cur_expert_next = cur_expert_reg + 5'd1;
                        cur_token_next  = '0;
                        hits_next       = '0;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    // Miss: read the following row while this one is dropped.
                    ram_re         = 1'b1;
                    ram_raddr      = token_inc[ADDR_W-1:0];
                    cur_token_next = token_inc[CNT_W-1:0];
                end
            end

            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = pend_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            expert_total_reg <= 5'd16;
            rows_loaded_reg  <= '0;
            for (int i = 0; i < EXPERT_SLOTS; i++)
            begin
                counts_reg[i] <= '0;
            end
            cur_expert_reg   <= '0;
            cur_token_reg    <= '0;
            hits_reg         <= '0;
            map_complete_reg <= 1'b0;
            dropped_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            expert_total_reg <= expert_total_next;
            rows_loaded_reg  <= rows_loaded_next;
            counts_reg       <= counts_next;
            cur_expert_reg   <= cur_expert_next;
            cur_token_reg    <= cur_token_next;
            hits_reg         <= hits_next;
            map_complete_reg <= map_complete_next;
            dropped_reg      <= dropped_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/etpi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module etpi_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 256
    )
    (
        input  logic                                 clk,
        input  logic                                 we,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
        input  logic [WIDTH-1:0]                     wdata,
        input  logic                                 re,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
        output logic [WIDTH-1:0]                     rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/etpi_dispatch_checker.sv
// Checker that predicts and scores every response word of the permutation index block.
`timescale 1ns / 100ps

module etpi_dispatch_checker
    import etpi_pkg::*;
    #(
        parameter int MAX_TOKENS  = 256,
        parameter int MAX_EXPERTS = 16
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        req_valid,
        input  logic        req_ready,
        input  etpi_req_t   req,
        input  logic        rsp_valid,
        input  logic        rsp_ready,
        input  etpi_rsp_t   rsp,
        input  logic        psel,
        input  logic        penable,
        input  logic        pwrite,
        input  logic [2:0]  paddr,
        input  logic [31:0] pwdata,
        input  logic        pready,
        output int          error_count,
        output int          words_pending
    );

    localparam logic [2:0] ADDR_EXPERT_TOTAL = 3'(4 * REG_EXPERT_TOTAL);

    // Mirror of the block's routing map, counts and dispatch cursor.
    logic [4:0]  expert_total_reg;
    logic [15:0] route_rows [MAX_TOKENS];
    int          rows_held;
    int          tokens_of_expert [EXPERT_SLOTS];
    int          cursor_exp;
    int          cursor_tok;
    bit          map_closed;
    bit          rows_dropped;

    // Response words still owed by the block, oldest first.
    etpi_rsp_t   expected_words [$];
    int          mismatches;

    // Number of experts that the register value stands for.
    function automatic int experts_in_force();
        int n;
        n = int'(expert_total_reg);
        if (n == 0) n = 1;
        if (n > MAX_EXPERTS) n = MAX_EXPERTS;
        if (n > EXPERT_SLOTS) n = EXPERT_SLOTS;
        return n;
    endfunction

    // Finds the first routed (expert, token) pair at or after the given position,
    // walking expert-major over the rows of the current map.
    function automatic bit next_routed(input int from_exp, input int from_tok,
                                       output int hit_exp, output int hit_tok);
        int n;
        int e;
        int t;
        n = experts_in_force();
        hit_exp = 0;
        hit_tok = 0;
        for (e = from_exp; e < n; e++) begin
            for (t = (e == from_exp) ? from_tok : 0; t < rows_held && t < MAX_TOKENS; t++) begin
                if (route_rows[t][e]) begin
                    hit_exp = e;
                    hit_tok = t;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one accepted request word and queues the response word it causes.
    task automatic predict_request(input etpi_req_t w);
        int          n;
        int          e;
        int          hit_exp;
        int          hit_tok;
        int          peek_exp;
        int          peek_tok;
        logic [15:0] kept;
        etpi_rsp_t   word;
        n = experts_in_force();
        word = '0;
        word.overflow_flag = rows_dropped;
        case (w.req_type)
            REQ_LOAD: begin
                // A load after the final row opens a fresh map.
                if (map_closed) begin
                    rows_held = 0;
                    foreach (tokens_of_expert[i]) tokens_of_expert[i] = 0;
                    cursor_exp = 0;
                    cursor_tok = 0;
                    map_closed = 1'b0;
                    rows_dropped = 1'b0;
                end
                kept = w.expert_mask & 16'((32'd1 << n) - 1);
                if (rows_held < MAX_TOKENS) begin
                    route_rows[rows_held] = kept;
                    for (e = 0; e < n; e++) begin
                        if (kept[e]) tokens_of_expert[e]++;
                    end
                    rows_held++;
                end
                else begin
                    rows_dropped = 1'b1;
                end
                if (w.final_row) map_closed = 1'b1;
            end
            REQ_QUERY: begin
                word.expert_index = w.query_expert;
                if (int'(w.query_expert) < n) begin
                    word.expert_count = 9'(tokens_of_expert[w.query_expert]);
                end
                expected_words = {expected_words, word};
            end
            REQ_FETCH: begin
                // Nothing is handed out before the final row or once the map is used up.
                if (map_closed) begin
                    if (next_routed(cursor_exp, cursor_tok, hit_exp, hit_tok)) begin
                        word.entry_valid  = 1'b1;
                        word.token_index  = 8'(hit_tok);
                        word.expert_index = 4'(hit_exp);
                        word.flat_index   = 12'(hit_tok * n + hit_exp);
                        word.expert_count = 9'(tokens_of_expert[hit_exp]);
                        if (hit_tok + 1 < rows_held) begin
                            cursor_exp = hit_exp;
                            cursor_tok = hit_tok + 1;
                        end
                        else begin
                            cursor_exp = hit_exp + 1;
                            cursor_tok = 0;
                        end
                        word.last_entry = !next_routed(cursor_exp, cursor_tok,
                                                       peek_exp, peek_tok);
                    end
                end
                expected_words = {expected_words, word};
            end
            default: begin
                // The unused request code is dropped without effect.
            end
        endcase
    endtask

    // Compares one field of a response word.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Watch the three ports at every edge; responses are scored before new requests.
    always @(posedge clk or negedge rst_n) begin
        etpi_rsp_t want;
        if (!rst_n) begin
            expert_total_reg = 5'd16;
            rows_held = 0;
            foreach (tokens_of_expert[i]) tokens_of_expert[i] = 0;
            cursor_exp = 0;
            cursor_tok = 0;
            map_closed = 1'b0;
            rows_dropped = 1'b0;
            expected_words.delete();
            mismatches = 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_EXPERT_TOTAL) begin
                expert_total_reg = pwdata[4:0];
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_words.size() == 0) begin
                    $error("response word with no request waiting for it");
                    mismatches++;
                end
                else begin
                    want = expected_words.pop_front();
                    check_field("entry_valid", 32'(want.entry_valid), 32'(rsp.entry_valid));
                    check_field("token_index", 32'(want.token_index), 32'(rsp.token_index));
                    check_field("expert_index", 32'(want.expert_index),
                                32'(rsp.expert_index));
                    check_field("flat_index", 32'(want.flat_index), 32'(rsp.flat_index));
                    check_field("expert_count", 32'(want.expert_count),
                                32'(rsp.expert_count));
                    check_field("last_entry", 32'(want.last_entry), 32'(rsp.last_entry));
                    check_field("overflow_flag", 32'(want.overflow_flag),
                                32'(rsp.overflow_flag));
                end
            end
            if (req_valid && req_ready) begin
                predict_request(req);
            end
        end
        error_count   <= mismatches;
        words_pending <= expected_words.size();
    end

endmodule

FILE: tb/tb_expert_token_permutation_index_core.sv
// Stimulus and verdict for the expert token permutation index block.
`timescale 1ns / 100ps

module tb_expert_token_permutation_index_core;
    import etpi_pkg::*;

    localparam int         MAX_TOKENS     = 256;
    localparam int         MAX_EXPERTS    = 16;
    localparam int         ITEM_TARGET    = 1350;
    localparam int         SUBPHASES      = 4;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         TAIL_CYCLES    = 64;
    // A fetch may walk every expert and every stored row; this is many times that.
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam logic [2:0] ADDR_EXPERT_TOTAL = 3'(4 * REG_EXPERT_TOTAL);

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    etpi_req_t   req_word;
    logic        rsp_valid;
    logic        rsp_ready;
    etpi_rsp_t   rsp_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          words_pending;
    int          stall_cycles = 0;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          mode;
    int          sub;
    int          sent_items;
    int          phase_end;
    int          map_entries;
    bit          map_ready;
    bit          big_pending;
    bit          big_done;
    logic [15:0] expert_lim;
    logic [4:0]  cfg_plan [3 * SUBPHASES];

    always #2 clk = ~clk;

    expert_token_permutation_index_core #(
        .MAX_TOKENS  (MAX_TOKENS),
        .MAX_EXPERTS (MAX_EXPERTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    etpi_dispatch_checker #(
        .MAX_TOKENS  (MAX_TOKENS),
        .MAX_EXPERTS (MAX_EXPERTS)
    ) dispatch_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req_word),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp_word),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    // The response side stalls at random.
    always @(posedge clk) begin
        rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Ends the run when no word and no register write has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("expert_token_permutation_index_core test failed");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one request word, with a random gap first, and waits until it is taken.
    task automatic send_request(input logic [1:0] kind, input logic [15:0] mask,
                                input logic fin, input logic [3:0] qexp);
        if ($urandom_range(99) < src_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_valid <= 1'b1;
        req_word  <= '{req_type: kind, expert_mask: mask, final_row: fin,
                       query_expert: qexp};
        do @(posedge clk); while (!req_ready);
        if (kind != REQ_UNUSED) sent_items++;
    endtask

    // Holds the request side until every response word has come and the block is quiet.
    task automatic drain_block();
        req_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes expert_total through the register port.
    task automatic write_expert_total(input logic [4:0] value);
        int eff;
        eff = (value == 0) ? 1 : ((value > 16) ? 16 : int'(value));
        expert_lim = 16'((32'd1 << eff) - 1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_EXPERT_TOTAL;
        pwdata  <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Routing row of a chosen density, with the all-clear and all-set rows now and then.
    function automatic logic [15:0] random_mask(input int density);
        case (density)
            0:       return 16'($urandom & $urandom & $urandom);
            1:       return 16'($urandom);
            2:       return 16'($urandom | $urandom);
            default: begin
                case ($urandom_range(2))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    default: return 16'(32'd1 << $urandom_range(15));
                endcase
            end
        endcase
    endfunction

    // Loads one map; a few stray queries, early fetches and unused codes land in between.
    task automatic load_map();
        int          rows;
        int          r;
        int          roll;
        int          density;
        logic [15:0] m;
        density = $urandom_range(3);
        if (!big_done) begin
            // One map runs past the store so that rows get dropped.
            rows = MAX_TOKENS + $urandom_range(1, 3);
            density = 0;
            big_done = 1'b1;
            big_pending = 1'b1;
        end
        else if ($urandom_range(9) == 0) begin
            rows = $urandom_range(13, 40);
        end
        else begin
            rows = $urandom_range(1, 12);
        end
        map_entries = 0;
        for (r = 0; r < rows; r++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_request(REQ_QUERY, 16'($urandom), 1'($urandom), 4'($urandom));
            end
            else if (roll < 12) begin
                send_request(REQ_FETCH, 16'($urandom), 1'($urandom), 4'($urandom));
            end
            else if (roll < 14) begin
                send_request(REQ_UNUSED, 16'($urandom), 1'($urandom), 4'($urandom));
            end
            m = random_mask(density);
            if (r < MAX_TOKENS) map_entries += $countones(m & expert_lim);
            send_request(REQ_LOAD, m, r == rows - 1, 4'($urandom));
        end
        map_ready = 1'b1;
    endtask

    // Fetches the map to its end and a little past it, or ten times for the overlong map.
    // Queries mix in; the walk stops early once the phase has sent its share of words.
    task automatic fetch_map();
        int n;
        int f;
        int roll;
        n = big_pending ? 10 : map_entries + $urandom_range(0, 2);
        for (f = 0; f < n && sent_items < phase_end; f++) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                send_request(REQ_QUERY, 16'($urandom), 1'($urandom), 4'($urandom));
            end
            else if (roll < 14) begin
                send_request(REQ_UNUSED, 16'($urandom), 1'($urandom), 4'($urandom));
            end
            send_request(REQ_FETCH, 16'($urandom), 1'($urandom), 4'($urandom));
        end
        map_ready = 1'b0;
        big_pending = 1'b0;
    endtask

    // Hand-picked words: empty map, fetch before the final row, exhaustion, new map,
    // experts beyond the count in use and the unused request code.
    task automatic run_directed();
        send_request(REQ_QUERY, 16'h0000, 1'b0, 4'd0);
        send_request(REQ_FETCH, 16'h0000, 1'b0, 4'd0);
        send_request(REQ_UNUSED, 16'hFFFF, 1'b1, 4'd15);
        send_request(REQ_LOAD, 16'h8001, 1'b0, 4'd0);
        send_request(REQ_LOAD, 16'h0000, 1'b0, 4'd0);
        send_request(REQ_FETCH, 16'h0000, 1'b0, 4'd0);
        send_request(REQ_QUERY, 16'h0000, 1'b0, 4'd15);
        send_request(REQ_LOAD, 16'h8003, 1'b1, 4'd0);
        repeat (6) send_request(REQ_FETCH, 16'h0000, 1'b0, 4'd0);
        send_request(REQ_QUERY, 16'h0000, 1'b0, 4'd15);
        send_request(REQ_QUERY, 16'h0000, 1'b0, 4'd7);
        send_request(REQ_LOAD, 16'hFFFF, 1'b1, 4'd0);
        send_request(REQ_QUERY, 16'h0000, 1'b0, 4'd3);
        send_request(REQ_FETCH, 16'h0000, 1'b0, 4'd0);
        drain_block();
        write_expert_total(5'd1);
        send_request(REQ_LOAD, 16'hFFFF, 1'b1, 4'd0);
        repeat (2) send_request(REQ_FETCH, 16'h0000, 1'b0, 4'd0);
        send_request(REQ_QUERY, 16'h0000, 1'b0, 4'd5);
    endtask

    initial begin
        int i;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_word    = '0;
        rsp_ready   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        expert_lim  = 16'hFFFF;
        map_ready   = 1'b0;
        big_pending = 1'b0;
        big_done    = 1'b0;
        sent_items  = 0;
        phase_end   = 0;
        src_idle_pct  = 38;
        sink_idle_pct = 73;
        // Extremes first, then random register values.
        cfg_plan[0] = 5'd16;
        cfg_plan[1] = 5'd0;
        cfg_plan[2] = 5'd31;
        cfg_plan[3] = 5'd1;
        cfg_plan[4] = 5'd17;
        for (i = 5; i < 3 * SUBPHASES; i++) cfg_plan[i] = 5'($urandom_range(0, 31));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();

        // Three idling modes, each split into phases with their own expert_total.
        // Each phase takes an even share of the words still to be sent.
        for (mode = 0; mode < 3; mode++) begin
            for (sub = 0; sub < SUBPHASES; sub++) begin
                drain_block();
                if (sub == 0) begin
                    src_idle_pct   = (mode == 0) ? 38 : ((mode == 1) ? 73 : 0);
                    sink_idle_pct <= (mode == 0) ? 73 : ((mode == 1) ? 38 : 0);
                end
                write_expert_total(cfg_plan[mode * SUBPHASES + sub]);
                phase_end = sent_items + (ITEM_TARGET - sent_items)
                            / (3 * SUBPHASES - (mode * SUBPHASES + sub));
                while (sent_items < phase_end) begin
                    if (!map_ready) load_map();
                    else fetch_map();
                end
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && words_pending == 0) begin
            $display("expert_token_permutation_index_core test passed");
        end
        else begin
            $display("expert_token_permutation_index_core test failed");
        end
        $finish;
    end

endmodule
